// ===== hw/rtl/jbdc_pkg.sv =====
// Shared types and constants for the joystick Bezier drive curve.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package jbdc_pkg;

  // Defaults for the top-level parameters
  localparam int STICK_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 15;

  // Field and register widths
  localparam int SCALE_W    = 14;  // output_scale, drive_floor
  localparam int ZONE_W     = 7;   // zone_limit, full_scale_input
  localparam int POINT_W    = 16;  // curve points
  localparam int DRIVE_W    = 15;  // drive_value
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // t is a 16-bit fraction; t = 1.0 travels as a saturation flag
  localparam int T_W     = 16;
  localparam int DIGIT_W = 8;   // multiplier digit of a Horner step

  // Power-basis coefficients and Horner accumulators (signed)
  localparam int C3_W  = 19;
  localparam int C2_W  = 20;
  localparam int C1_W  = 19;
  localparam int C0_W  = 18;   // {p0, round bit}
  localparam int H2_W  = 37;
  localparam int H1_W  = 54;
  localparam int S_W   = 71;
  localparam int C2_SHIFT    = 16;
  localparam int C1_SHIFT    = 32;
  localparam int C0_SHIFT    = 47;
  localparam int CURVE_LSB   = 48;

  localparam int PROD_W    = SCALE_W + POINT_W;
  localparam int OUT_LIMIT = 12000;

  // Register reset values
  localparam logic [ZONE_W-1:0]  ZONE_LIMIT_RST  = 7'd5;
  localparam logic [ZONE_W-1:0]  FULL_SCALE_RST  = 7'd127;
  localparam logic [SCALE_W-1:0] DRIVE_FLOOR_RST = 14'd0;
  localparam logic [POINT_W-1:0] POINT0_RST      = 16'd0;
  localparam logic [POINT_W-1:0] POINT1_RST      = 16'd10923;
  localparam logic [POINT_W-1:0] POINT2_RST      = 16'd21845;
  localparam logic [POINT_W-1:0] POINT3_RST      = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_LIMIT  = 3'd0,
    REG_FULL_SCALE  = 3'd1,
    REG_DRIVE_FLOOR = 3'd2,
    REG_POINT_0     = 3'd3,
    REG_POINT_1     = 3'd4,
    REG_POINT_2     = 3'd5,
    REG_POINT_3     = 3'd6
  } reg_idx_t;

  // Per-sample sideband carried down the whole pipe
  typedef struct packed {
    logic               neg;   // stick negative
    logic               zero;  // inside dead zone
    logic               sat;   // t = 1.0
    logic               dneg;  // output_scale < drive_floor
    logic [SCALE_W-1:0] dmag;  // |output_scale - drive_floor|
  } side_t;

endpackage

// ===== hw/rtl/jbdc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of t per cycle while en is high.
// Depends on jbdc_pkg.
`timescale 1ns / 1ps

module jbdc_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [jbdc_pkg::ZONE_W-1:0]   span,
  input  logic                          in_valid,
  input  jbdc_pkg::side_t               in_side,
  input  logic [jbdc_pkg::ZONE_W-1:0]   in_rem,
  input  logic [jbdc_pkg::T_W-1:0]      in_quot,
  output logic                          out_valid,
  output jbdc_pkg::side_t               out_side,
  output logic [jbdc_pkg::ZONE_W-1:0]   out_rem,
  output logic [jbdc_pkg::T_W-1:0]      out_quot
);

  logic [jbdc_pkg::ZONE_W:0]   rem2;
  logic [jbdc_pkg::ZONE_W:0]   span_x;
  logic                        ge;
  logic [jbdc_pkg::ZONE_W:0]   diff;

  assign rem2   = {in_rem, 1'b0};
  assign span_x = {1'b0, span};
  assign ge     = rem2 >= span_x;
  assign diff   = rem2 - span_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // remainder stays below span, so it fits back into ZONE_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= ge ? diff[jbdc_pkg::ZONE_W-1:0] : rem2[jbdc_pkg::ZONE_W-1:0];
      out_quot <= {in_quot[jbdc_pkg::T_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/jbdc_horner_step.sv =====
// One Horner step acc' = acc * t + (add << ADD_SHIFT), split over two cells
// that each multiply by one 8-bit digit of t.  Depends on jbdc_pkg.
`timescale 1ns / 1ps

module jbdc_horner_step #(
  parameter int IN_W      = jbdc_pkg::C3_W,
  parameter int ADD_W     = jbdc_pkg::C2_W,
  parameter int ADD_SHIFT = jbdc_pkg::C2_SHIFT,
  parameter int OUT_W     = jbdc_pkg::H2_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic signed [ADD_W-1:0]     add,
  input  logic                        in_valid,
  input  jbdc_pkg::side_t             in_side,
  input  logic [jbdc_pkg::T_W-1:0]    in_t,
  input  logic signed [IN_W-1:0]      in_acc,
  output logic                        out_valid,
  output jbdc_pkg::side_t             out_side,
  output logic [jbdc_pkg::T_W-1:0]    out_t,
  output logic signed [OUT_W-1:0]     out_acc
);

  localparam int LO_W = IN_W + jbdc_pkg::DIGIT_W + 1;

  logic                      a_valid;
  jbdc_pkg::side_t           a_side;
  logic [jbdc_pkg::T_W-1:0]  a_t;
  logic signed [IN_W-1:0]    a_acc;
  logic signed [LO_W-1:0]    a_lo;

  logic signed [LO_W-1:0]    lo_prod;
  logic signed [OUT_W-1:0]   hi_prod;
  logic signed [OUT_W-1:0]   lo_ext;
  logic signed [OUT_W-1:0]   add_ext;
  logic signed [OUT_W-1:0]   acc_next;

  // cell A: low digit
  assign lo_prod = in_acc * $signed({1'b0, in_t[jbdc_pkg::DIGIT_W-1:0]});

  // cell B: high digit, plus low partial and the coefficient
  assign hi_prod  = a_acc * $signed({1'b0, a_t[jbdc_pkg::T_W-1:jbdc_pkg::DIGIT_W]});
  assign lo_ext   = OUT_W'(a_lo);
  assign add_ext  = OUT_W'(add) <<< ADD_SHIFT;
  assign acc_next = (hi_prod <<< jbdc_pkg::DIGIT_W) + lo_ext + add_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side   <= in_side;
      a_t      <= in_t;
      a_acc    <= in_acc;
      a_lo     <= lo_prod;
      out_side <= a_side;
      out_t    <= a_t;
      out_acc  <= acc_next;
    end
  end

endmodule

// ===== hw/rtl/joystick_bezier_drive_curve.sv =====
// Top level of the joystick Bezier drive curve.
// Depends on jbdc_pkg, jbdc_div_cell and jbdc_horner_step.
`timescale 1ns / 1ps

// Maps one signed stick sample plus a per-axis full-scale drive to a signed
// drive value in millivolts through a dead zone and a cubic Bezier curve.
//
// Input stream (s_axis_*): one transaction per sample, tdata holds
// stick_value and output_scale.  Output stream (m_axis_*): one transaction
// per sample, in order, tdata holds drive_value.  Config port: cfg_wr_en
// writes cfg_data into the register at cfg_index in the same cycle; indexes
// past the last curve point are dropped.  Write only while the pipe is empty.
//
// The datapath is a row of cells: one input cell (magnitude, dead zone,
// saturation test), 16 division cells that each produce one bit of t, six
// Horner cells (three steps, one 8-bit digit of t per cell), a scale
// multiply cell and a rounding cell.  A new sample is taken every cycle
// while s_axis_tready is high.
//
// All cells advance together.  The output register is backed by a one-entry
// skid register, so the input keeps flowing while one result waits; only
// when the skid register fills does s_axis_tready drop and the row freeze.
// Reset (rst, synchronous) empties the pipe and loads register defaults.

module joystick_bezier_drive_curve #(
  parameter int STICK_BITS = jbdc_pkg::STICK_BITS_DEF,
  parameter int FRAC_BITS  = jbdc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // stream in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [STICK_BITS-1:0] stick_value, [STICK_BITS+13:STICK_BITS] output_scale
  input  logic [((STICK_BITS+jbdc_pkg::SCALE_W+7)/8)*8-1:0] s_axis_tdata,
  // stream out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [14:0] drive_value
  output logic [jbdc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // config
  input  logic                                   cfg_wr_en,
  input  logic [jbdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jbdc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int ZW     = jbdc_pkg::ZONE_W;
  localparam int SW     = jbdc_pkg::SCALE_W;
  localparam int PW     = jbdc_pkg::POINT_W;
  localparam int TW     = jbdc_pkg::T_W;
  localparam int CMP_W  = ((STICK_BITS > ZW) ? STICK_BITS : ZW) + 1;
  localparam int Q_W    = jbdc_pkg::PROD_W - FRAC_BITS + 1;
  localparam int M_W    = ((Q_W > SW) ? Q_W : SW) + 2;
  localparam int RES_W  = M_W + 1;
  localparam int DW     = jbdc_pkg::DRIVE_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ZW-1:0] zone_limit;
  logic [ZW-1:0] full_scale_input;
  logic [SW-1:0] drive_floor;
  logic [PW-1:0] curve_point_0;
  logic [PW-1:0] curve_point_1;
  logic [PW-1:0] curve_point_2;
  logic [PW-1:0] curve_point_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_limit       <= jbdc_pkg::ZONE_LIMIT_RST;
      full_scale_input <= jbdc_pkg::FULL_SCALE_RST;
      drive_floor      <= jbdc_pkg::DRIVE_FLOOR_RST;
      curve_point_0    <= jbdc_pkg::POINT0_RST;
      curve_point_1    <= jbdc_pkg::POINT1_RST;
      curve_point_2    <= jbdc_pkg::POINT2_RST;
      curve_point_3    <= jbdc_pkg::POINT3_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jbdc_pkg::REG_ZONE_LIMIT:  zone_limit       <= cfg_data[ZW-1:0];
        jbdc_pkg::REG_FULL_SCALE:  full_scale_input <= cfg_data[ZW-1:0];
        jbdc_pkg::REG_DRIVE_FLOOR: drive_floor      <= cfg_data[SW-1:0];
        jbdc_pkg::REG_POINT_0:     curve_point_0    <= cfg_data[PW-1:0];
        jbdc_pkg::REG_POINT_1:     curve_point_1    <= cfg_data[PW-1:0];
        jbdc_pkg::REG_POINT_2:     curve_point_2    <= cfg_data[PW-1:0];
        jbdc_pkg::REG_POINT_3:     curve_point_3    <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Power-basis coefficients of the curve, refreshed every cycle.
  // B*2^48 = ((c3*t + c2*2^16)*t + c1*2^32)*t + p0*2^48
  logic signed [20:0] p0_s, p1_s, p2_s, p3_s;
  logic signed [20:0] c3_full, c2_full, c1_full;
  logic signed [jbdc_pkg::C3_W-1:0] coef3;
  logic signed [jbdc_pkg::C2_W-1:0] coef2;
  logic signed [jbdc_pkg::C1_W-1:0] coef1;
  logic signed [jbdc_pkg::C0_W-1:0] coef0;

  assign p0_s    = $signed({5'b0, curve_point_0});
  assign p1_s    = $signed({5'b0, curve_point_1});
  assign p2_s    = $signed({5'b0, curve_point_2});
  assign p3_s    = $signed({5'b0, curve_point_3});
  assign c3_full = p3_s - p0_s + 21'sd3 * (p1_s - p2_s);
  assign c2_full = 21'sd3 * (p0_s - (p1_s <<< 1) + p2_s);
  assign c1_full = 21'sd3 * (p1_s - p0_s);

  always_ff @(posedge clk) begin
    coef3 <= c3_full[jbdc_pkg::C3_W-1:0];
    coef2 <= c2_full[jbdc_pkg::C2_W-1:0];
    coef1 <= c1_full[jbdc_pkg::C1_W-1:0];
    coef0 <= $signed({1'b0, curve_point_0, 1'b1});  // p0 plus the rounding half
  end

  // ---------------------------------------------------------------------
  // Flow control: whole row steps while the skid register is empty
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid;
  logic out_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------
  // Input cell
  // ---------------------------------------------------------------------
  logic [STICK_BITS-1:0] raw;
  logic                  in_neg;
  logic [STICK_BITS-1:0] mag;
  logic [CMP_W-1:0]      mag_x, dz_x, excess;
  logic [ZW-1:0]         span;
  logic                  span_empty;
  logic [SW-1:0]         scale;
  logic [SW:0]           sdiff, sdiff_neg;
  jbdc_pkg::side_t       in_side;

  assign raw        = s_axis_tdata[STICK_BITS-1:0];
  assign in_neg     = raw[STICK_BITS-1];
  assign mag        = in_neg ? (~raw + 1'b1) : raw;  // most negative -> 2^(N-1)
  assign mag_x      = CMP_W'(mag);
  assign dz_x       = CMP_W'(zone_limit);
  assign excess     = mag_x - dz_x;
  assign span_empty = full_scale_input <= zone_limit;
  assign span       = full_scale_input - zone_limit;
  assign scale      = s_axis_tdata[STICK_BITS+SW-1:STICK_BITS];
  assign sdiff      = {1'b0, scale} - {1'b0, drive_floor};
  assign sdiff_neg  = -sdiff;

  assign in_side.neg  = in_neg;
  assign in_side.zero = mag_x < dz_x;
  assign in_side.sat  = span_empty || (excess >= CMP_W'(span));
  assign in_side.dneg = sdiff[SW];
  assign in_side.dmag = sdiff[SW] ? sdiff_neg[SW-1:0] : sdiff[SW-1:0];

  logic                 div_valid [0:TW];
  jbdc_pkg::side_t      div_side  [0:TW];
  logic [ZW-1:0]        div_rem   [0:TW];
  logic [TW-1:0]        div_quot  [0:TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (en) begin
      div_valid[0] <= s_axis_tvalid;
    end
  end

  // remainder is only meaningful when excess < span, so it fits ZW bits
  always_ff @(posedge clk) begin
    if (en) begin
      div_side[0] <= in_side;
      div_rem[0]  <= excess[ZW-1:0];
      div_quot[0] <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Division cells: t = floor(excess * 2^16 / span), one bit per cell
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < TW; i++) begin : g_div
    jbdc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .span      (span),
      .in_valid  (div_valid[i]),
      .in_side   (div_side[i]),
      .in_rem    (div_rem[i]),
      .in_quot   (div_quot[i]),
      .out_valid (div_valid[i+1]),
      .out_side  (div_side[i+1]),
      .out_rem   (div_rem[i+1]),
      .out_quot  (div_quot[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Horner cells
  // ---------------------------------------------------------------------
  logic                                h2_valid, h1_valid, h0_valid;
  jbdc_pkg::side_t                     h2_side, h1_side, h0_side;
  logic [TW-1:0]                       h2_t, h1_t, h0_t;
  logic signed [jbdc_pkg::H2_W-1:0]    h2_acc;
  logic signed [jbdc_pkg::H1_W-1:0]    h1_acc;
  logic signed [jbdc_pkg::S_W-1:0]     h0_acc;

  jbdc_horner_step #(
    .IN_W      (jbdc_pkg::C3_W),
    .ADD_W     (jbdc_pkg::C2_W),
    .ADD_SHIFT (jbdc_pkg::C2_SHIFT),
    .OUT_W     (jbdc_pkg::H2_W)
  ) u_step3 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .add       (coef2),
    .in_valid  (div_valid[TW]),
    .in_side   (div_side[TW]),
    .in_t      (div_quot[TW]),
    .in_acc    (coef3),
    .out_valid (h2_valid),
    .out_side  (h2_side),
    .out_t     (h2_t),
    .out_acc   (h2_acc)
  );

  jbdc_horner_step #(
    .IN_W      (jbdc_pkg::H2_W),
    .ADD_W     (jbdc_pkg::C1_W),
    .ADD_SHIFT (jbdc_pkg::C1_SHIFT),
    .OUT_W     (jbdc_pkg::H1_W)
  ) u_step2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .add       (coef1),
    .in_valid  (h2_valid),
    .in_side   (h2_side),
    .in_t      (h2_t),
    .in_acc    (h2_acc),
    .out_valid (h1_valid),
    .out_side  (h1_side),
    .out_t     (h1_t),
    .out_acc   (h1_acc)
  );

  jbdc_horner_step #(
    .IN_W      (jbdc_pkg::H1_W),
    .ADD_W     (jbdc_pkg::C0_W),
    .ADD_SHIFT (jbdc_pkg::C0_SHIFT),
    .OUT_W     (jbdc_pkg::S_W)
  ) u_step1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .add       (coef0),
    .in_valid  (h1_valid),
    .in_side   (h1_side),
    .in_t      (h1_t),
    .in_acc    (h1_acc),
    .out_valid (h0_valid),
    .out_side  (h0_side),
    .out_t     (h0_t),
    .out_acc   (h0_acc)
  );

  // ---------------------------------------------------------------------
  // Scale cell: |output_scale - drive_floor| * curve
  // ---------------------------------------------------------------------
  logic [PW-1:0]                  curve;
  logic                           p_valid;
  jbdc_pkg::side_t                p_side;
  logic [jbdc_pkg::PROD_W-1:0]    p_prod;

  // t = 1.0 lands exactly on the last control point
  assign curve = h0_side.sat ? curve_point_3
                             : h0_acc[jbdc_pkg::CURVE_LSB+PW-1:jbdc_pkg::CURVE_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= h0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= h0_side;
      p_prod <= h0_side.dmag * curve;
    end
  end

  // ---------------------------------------------------------------------
  // Rounding cell: m = drive_floor +/- round(prod / 2^FRAC_BITS)
  // ---------------------------------------------------------------------
  localparam logic [jbdc_pkg::PROD_W:0] HALF = (jbdc_pkg::PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic [jbdc_pkg::PROD_W:0] q_sum;
  logic [Q_W-1:0]            q;
  logic signed [M_W-1:0]     q_s, min_s, m_next;
  logic                      r_valid, r_neg, r_zero;
  logic signed [M_W-1:0]     r_m;

  assign q_sum  = {1'b0, p_prod} + HALF;
  assign q      = q_sum[jbdc_pkg::PROD_W:FRAC_BITS];
  assign q_s    = M_W'(q);
  assign min_s  = M_W'(drive_floor);
  assign m_next = min_s + (p_side.dneg ? -q_s : q_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_neg  <= p_side.neg;
      r_zero <= p_side.zero;
      r_m    <= m_next;
    end
  end

  // ---------------------------------------------------------------------
  // Sign, clamp, output register and skid register
  // ---------------------------------------------------------------------
  localparam logic signed [RES_W-1:0] LIM_HI = RES_W'(jbdc_pkg::OUT_LIMIT);
  localparam logic signed [RES_W-1:0] LIM_LO = -LIM_HI;

  logic signed [RES_W-1:0] m_ext, res;
  logic [DW-1:0]           fin_data;
  logic [DW-1:0]           out_data;
  logic [DW-1:0]           skid_data;

  assign m_ext = RES_W'(r_m);
  assign res   = r_neg ? -m_ext : m_ext;

  always_comb begin
    if (r_zero) begin
      fin_data = '0;
    end else if (res > LIM_HI) begin
      fin_data = LIM_HI[DW-1:0];
    end else if (res < LIM_LO) begin
      fin_data = LIM_LO[DW-1:0];
    end else begin
      fin_data = res[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (r_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
      end
    end else if (r_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_data <= fin_data;
      end else begin
        skid_data <= fin_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(jbdc_pkg::OUT_TDATA_W-DW){1'b0}}, out_data};

`ifndef SYNTHESIS
  // skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // a taken output drains the skid register in the next cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && m_axis_tready |=> !skid_valid)
    else $error("skid register not drained");

  // drive stays within the clamp range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data) <= $signed(LIM_HI[DW-1:0]) &&
                   $signed(out_data) >= $signed(LIM_LO[DW-1:0])))
    else $error("drive value outside clamp range");

  // the Bezier sum lies in [0, 2^64) so the curve fits its 16 bits
  a_curve_fits: assert property (@(posedge clk) disable iff (rst)
    h0_valid && !h0_side.sat |->
      h0_acc[jbdc_pkg::S_W-1:jbdc_pkg::CURVE_LSB+PW] == '0)
    else $error("curve accumulator out of range");
`endif

endmodule

// ===== verif/jbdc_drive_checker.sv =====
// Scoreboard for the joystick Bezier drive curve: watches both streams and
// the config port, predicts drive_value per sample and compares in order.
// Depends on jbdc_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module jbdc_drive_checker #(
  parameter int STICK_BITS = jbdc_pkg::STICK_BITS_DEF,
  parameter int FRAC_BITS  = jbdc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  // [STICK_BITS-1:0] stick_value, [STICK_BITS+13:STICK_BITS] output_scale
  input  logic [((STICK_BITS+jbdc_pkg::SCALE_W+7)/8)*8-1:0] in_data,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  // [14:0] drive_value
  input  logic [jbdc_pkg::OUT_TDATA_W-1:0]       out_data,
  input  logic                                   cfg_wr_en,
  input  logic [jbdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jbdc_pkg::CFG_DATA_W-1:0]        cfg_data,
  output int                                     mismatches,
  output int                                     drives_outstanding
);

  // shadow copy of the block's registers
  logic [jbdc_pkg::ZONE_W-1:0]  zone_limit;
  logic [jbdc_pkg::ZONE_W-1:0]  full_scale;
  logic [jbdc_pkg::SCALE_W-1:0] min_out;
  logic [jbdc_pkg::POINT_W-1:0] point [4];

  logic [jbdc_pkg::DRIVE_W-1:0] expected_drive [$];

  function automatic logic [jbdc_pkg::DRIVE_W-1:0] drive_for(
      input logic [STICK_BITS-1:0] stick,
      input logic [jbdc_pkg::SCALE_W-1:0] scale);
    logic neg;
    longint unsigned mag, excess, span, t, u, w0, w1, w2, w3, acc, curve, dmag, q;
    longint signed scale_s, min_s, diff, term, level, drive;
    neg = stick[STICK_BITS-1];
    mag = 64'(stick);
    if (neg) mag = (64'd1 << STICK_BITS) - mag;
    if (mag < 64'(zone_limit)) return '0;
    excess = mag - 64'(zone_limit);
    if (full_scale <= zone_limit) begin
      t = 64'd65536;
    end else begin
      span = 64'(full_scale) - 64'(zone_limit);
      t = (excess << 16) / span;
      if (t > 64'd65536) t = 64'd65536;
    end
    // Bernstein weights sum to 2^48
    u = 64'd65536 - t;
    w0 = u * u * u;
    w1 = 64'd3 * u * u * t;
    w2 = 64'd3 * u * t * t;
    w3 = t * t * t;
    acc = 64'(point[0]) * w0 + 64'(point[1]) * w1 + 64'(point[2]) * w2
        + 64'(point[3]) * w3 + (64'd1 << 47);
    curve = acc >> 48;
    scale_s = scale;
    min_s = min_out;
    diff = scale_s - min_s;
    dmag = (diff < 0) ? -diff : diff;
    q = (dmag * curve + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    term = q;
    level = min_s + ((diff < 0) ? -term : term);
    drive = neg ? -level : level;
    if (drive > jbdc_pkg::OUT_LIMIT) drive = jbdc_pkg::OUT_LIMIT;
    if (drive < -jbdc_pkg::OUT_LIMIT) drive = -jbdc_pkg::OUT_LIMIT;
    return drive[jbdc_pkg::DRIVE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [jbdc_pkg::DRIVE_W-1:0] want, got;
    if (rst) begin
      zone_limit <= jbdc_pkg::ZONE_LIMIT_RST;
      full_scale <= jbdc_pkg::FULL_SCALE_RST;
      min_out    <= jbdc_pkg::DRIVE_FLOOR_RST;
      point[0]   <= jbdc_pkg::POINT0_RST;
      point[1]   <= jbdc_pkg::POINT1_RST;
      point[2]   <= jbdc_pkg::POINT2_RST;
      point[3]   <= jbdc_pkg::POINT3_RST;
      expected_drive.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          jbdc_pkg::REG_ZONE_LIMIT:  zone_limit <= cfg_data[jbdc_pkg::ZONE_W-1:0];
          jbdc_pkg::REG_FULL_SCALE:  full_scale <= cfg_data[jbdc_pkg::ZONE_W-1:0];
          jbdc_pkg::REG_DRIVE_FLOOR: min_out    <= cfg_data[jbdc_pkg::SCALE_W-1:0];
          jbdc_pkg::REG_POINT_0:     point[0]   <= cfg_data;
          jbdc_pkg::REG_POINT_1:     point[1]   <= cfg_data;
          jbdc_pkg::REG_POINT_2:     point[2]   <= cfg_data;
          jbdc_pkg::REG_POINT_3:     point[3]   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_drive.push_back(drive_for(in_data[STICK_BITS-1:0],
                                           in_data[STICK_BITS +: jbdc_pkg::SCALE_W]));
      if (out_valid && out_ready) begin
        got = out_data[jbdc_pkg::DRIVE_W-1:0];
        if (expected_drive.size() == 0) begin
          $display("%0t: drive_value with no sample pending: expected none, actual %0d",
                   $time, $signed(got));
          mismatches++;
        end else begin
          want = expected_drive.pop_front();
          if (got !== want) begin
            $display("%0t: drive_value mismatch: expected %0d, actual %0d",
                     $time, $signed(want), $signed(got));
            mismatches++;
          end
        end
      end
    end
    drives_outstanding = expected_drive.size();
  end

endmodule

// ===== verif/tb_joystick_bezier_drive_curve.sv =====
// Testbench top for the joystick Bezier drive curve: clock, reset, stimulus,
// config phases and verdict. Depends on jbdc_pkg, the block and jbdc_drive_checker.
`timescale 1ns / 1ps

module tb_joystick_bezier_drive_curve;

  localparam int STICK_BITS  = jbdc_pkg::STICK_BITS_DEF;
  localparam int IN_W        = ((STICK_BITS + jbdc_pkg::SCALE_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;   // well past the depth of the pipe plus skid
  localparam int MAX_GAP     = 18;
  // index past the last curve point; the block must drop the write
  localparam logic [jbdc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [IN_W-1:0]                 s_axis_tdata;   // stick_value, output_scale
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [jbdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // drive_value
  logic                            cfg_wr_en;
  logic [jbdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jbdc_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int drives_outstanding;
  int cycle_count = 0;

  // burst and hold_req are shared between the sender and the receiver process
  bit burst    = 1'b0;   // no idling on either side
  bit hold_req = 1'b0;   // receiver holds off for a long stretch once
  int cur_zone_limit = jbdc_pkg::ZONE_LIMIT_RST;

  initial forever #6 clk = ~clk;

  joystick_bezier_drive_curve uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  jbdc_drive_checker #(.STICK_BITS(STICK_BITS)) drive_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s_axis_tvalid),
    .in_ready           (s_axis_tready),
    .in_data            (s_axis_tdata),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_data           (m_axis_tdata),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .drives_outstanding (drives_outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One sample transaction; tvalid stays high across back-to-back samples.
  task automatic send_sample(input int stick, input int scale);
    logic [IN_W-1:0] word;
    int gap;
    word = '0;
    word[STICK_BITS-1:0] = stick[STICK_BITS-1:0];
    word[STICK_BITS +: jbdc_pkg::SCALE_W] = scale[jbdc_pkg::SCALE_W-1:0];
    if (burst) gap = 0;
    else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every drive value has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (drives_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jbdc_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[jbdc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Write every register in turn; only called with the pipe empty.
  task automatic set_config(input int dz, input int fs, input int mn,
                            input int p0, input int p1, input int p2, input int p3);
    write_reg(jbdc_pkg::REG_ZONE_LIMIT, dz);
    write_reg(jbdc_pkg::REG_FULL_SCALE, fs);
    write_reg(jbdc_pkg::REG_DRIVE_FLOOR, mn);
    write_reg(jbdc_pkg::REG_POINT_0, p0);
    write_reg(jbdc_pkg::REG_POINT_1, p1);
    write_reg(jbdc_pkg::REG_POINT_2, p2);
    write_reg(jbdc_pkg::REG_POINT_3, p3);
    cfg_wr_en <= 1'b0;
    cur_zone_limit = dz;
  endtask

  function automatic int pick_point(input bit extreme);
    if (extreme) return ($urandom_range(0, 1) != 0) ? 32768 : 0;
    // now and then a point above 1.0
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 32768);
  endfunction

  task automatic random_config(input bit extreme);
    int dz, fs, mn;
    if (extreme) begin
      dz = ($urandom_range(0, 3) == 0) ? 127 : 0;
      fs = ($urandom_range(0, 3) == 0) ? 1 : 127;
      mn = ($urandom_range(0, 1) != 0) ? 12000 : 0;
    end else begin
      dz = $urandom_range(0, 40);
      // mostly a real span, sometimes an empty one
      fs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(dz, 127);
      mn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 12000);
    end
    set_config(dz, fs, mn, pick_point(extreme), pick_point(extreme),
               pick_point(extreme), pick_point(extreme));
  endtask

  task automatic send_random();
    int stick, scale;
    if ($urandom_range(0, 3) == 0) begin
      // near the dead-zone edge, either sign
      stick = cur_zone_limit + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1) != 0) stick = -stick;
    end else begin
      stick = $urandom_range(0, 255);
    end
    if ($urandom_range(0, 4) == 0) scale = $urandom_range(0, 16383);
    else scale = $urandom_range(0, 12000);
    send_sample(stick, scale);
  endtask

  // Receiver: random stall per result, a long hold-off on request.
  initial begin
    int wait_cycles;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else if (burst) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: dead-zone edge, extremes of stick and scale,
    // most negative stick
    send_sample(0, 12000);
    send_sample(4, 12000);
    send_sample(5, 12000);
    send_sample(-5, 12000);
    send_sample(127, 12000);
    send_sample(-127, 12000);
    send_sample(-128, 12000);
    send_sample(64, 0);
    send_sample(-64, 16383);
    send_sample(100, 6000);
    wait_drained();

    // no dead zone (zero stick counts positive), scale below the floor,
    // points above 1.0 so the clamp bites; plus a dropped write
    write_reg(REG_SPARE, 16'hFFFF);
    set_config(0, 127, 12000, 65535, 65535, 65535, 65535);
    send_sample(0, 0);
    send_sample(0, 12000);
    send_sample(-128, 0);
    send_sample(127, 16383);
    send_sample(-1, 3000);
    wait_drained();

    // empty span: full scale below the dead zone
    set_config(127, 1, 0, 32768, 0, 65535, 0);
    send_sample(127, 12000);
    send_sample(-127, 12000);
    send_sample(-128, 8000);
    send_sample(126, 12000);
    send_sample(-126, 12000);
    wait_drained();

    // magnitudes at or beyond full scale saturate t; one inside the span does not
    set_config(10, 20, 1000, 0, 10923, 21845, 32768);
    send_sample(30, 9000);
    send_sample(-20, 9000);
    send_sample(15, 500);
    wait_drained();

    // random phases; each starts from an empty pipe with fresh registers
    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase % 3 == 0);
      burst = (phase == 2 || phase == 3 || phase == 6);
      // receiver stalls long while samples keep coming: fills the pipe
      if (phase == 3) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) send_random();
      wait_drained();
    end
    burst = 1'b0;

    repeat (30) @(posedge clk);
    if (mismatches == 0 && drives_outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
